### hdl/qrv_pkg.sv
// ----------------------------------------------------------------------------
// qrv_pkg
// Widths, payload types, register codes and the rounding and saturation
// helpers shared by the quaternion vector rotation pipeline.
// ----------------------------------------------------------------------------
package qrv_pkg;

	// Field widths
	localparam int VEC_W  = 16;            // vector component width
	localparam int QF     = 15;            // quaternion fraction bits
	localparam int QUAT_W = QF + 1;        // quaternion component width

	// Datapath widths
	localparam int P1_W  = QUAT_W + VEC_W; // q * v product
	localparam int D1_W  = P1_W + 1;       // difference of two products
	localparam int U_W   = VEC_W + 2;      // rounded first cross product
	localparam int P2_W  = QUAT_W + U_W;   // q * u product
	localparam int D2_W  = P2_W + 1;       // difference of two products
	localparam int S_W   = U_W + 1;        // rounded 2*w*u
	localparam int DD_W  = U_W + 4;        // rounded 2*(qv x u)
	localparam int SUM_W = DD_W + 1;       // v + s + d before saturation

	// Configuration register map
	localparam int CFG_IDX_W = 2;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_QUAT_W,
		REG_QUAT_X,
		REG_QUAT_Y,
		REG_QUAT_Z
	} cfg_idx_t;

	// Reset value of the scalar part: largest positive value, close to 1.0
	localparam logic [QUAT_W-1:0] QUAT_W_RST = QUAT_W'((1 << QF) - 1);

	typedef struct packed {
		logic signed [VEC_W-1:0] x;
		logic signed [VEC_W-1:0] y;
		logic signed [VEC_W-1:0] z;
	} vec3_t;

	typedef struct packed {
		logic signed [QUAT_W-1:0] w;
		logic signed [QUAT_W-1:0] x;
		logic signed [QUAT_W-1:0] y;
		logic signed [QUAT_W-1:0] z;
	} quat_t;

	typedef struct packed {
		logic signed [U_W-1:0] x;
		logic signed [U_W-1:0] y;
		logic signed [U_W-1:0] z;
	} uvec_t;

	// Payload handed from the first cross product to the rotation stages
	typedef struct packed {
		vec3_t v;
		uvec_t u;
	} ustg_t;

	// Six partial products of a cross product
	typedef struct packed {
		logic signed [P1_W-1:0] yz;
		logic signed [P1_W-1:0] zy;
		logic signed [P1_W-1:0] zx;
		logic signed [P1_W-1:0] xz;
		logic signed [P1_W-1:0] xy;
		logic signed [P1_W-1:0] yx;
	} xprod1_t;

	typedef struct packed {
		logic signed [P2_W-1:0] yz;
		logic signed [P2_W-1:0] zy;
		logic signed [P2_W-1:0] zx;
		logic signed [P2_W-1:0] xz;
		logic signed [P2_W-1:0] xy;
		logic signed [P2_W-1:0] yx;
	} xprod2_t;

	typedef struct packed {
		logic signed [P2_W-1:0] x;
		logic signed [P2_W-1:0] y;
		logic signed [P2_W-1:0] z;
	} wprod_t;

	// Round x / 2^QF to nearest, ties away from zero
	function automatic logic signed [U_W-1:0] rnd_u(input logic signed [D1_W-1:0] x);
		logic [D1_W:0] t;
		t = (D1_W+1)'(x) + ((D1_W+1)'(1) << (QF - 1)) - (D1_W+1)'(x[D1_W-1]);
		return t[QF+U_W-1:QF];
	endfunction

	// Round x / 2^(QF-1) to nearest, ties away from zero
	function automatic logic signed [DD_W-1:0] rnd_r(input logic signed [D2_W-1:0] x);
		logic [D2_W:0] t;
		t = (D2_W+1)'(x) + ((D2_W+1)'(1) << (QF - 2)) - (D2_W+1)'(x[D2_W-1]);
		return t[QF-1+DD_W-1:QF-1];
	endfunction

	// Clamp to the signed vector range
	function automatic logic signed [VEC_W-1:0] sat_vec(input logic signed [SUM_W-1:0] x);
		logic ovf;
		ovf = (x[SUM_W-1:VEC_W-1] != '0) && (x[SUM_W-1:VEC_W-1] != '1);
		if (!ovf) begin
			return x[VEC_W-1:0];
		end else if (x[SUM_W-1]) begin
			return {1'b1, {(VEC_W-1){1'b0}}};
		end else begin
			return {1'b0, {(VEC_W-1){1'b1}}};
		end
	endfunction

endpackage

### hdl/qrv_if.sv
// ----------------------------------------------------------------------------
// qrv_if
// Valid/ready channel interfaces: input vector, rotated vector and
// configuration write.
// ----------------------------------------------------------------------------
interface qrv_vec_if import qrv_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [VEC_W-1:0] vec_x;
	logic signed [VEC_W-1:0] vec_y;
	logic signed [VEC_W-1:0] vec_z;

	modport source (output valid, vec_x, vec_y, vec_z, input ready);
	modport sink   (input valid, vec_x, vec_y, vec_z, output ready);
endinterface

interface qrv_rot_if import qrv_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [VEC_W-1:0] rot_x;
	logic signed [VEC_W-1:0] rot_y;
	logic signed [VEC_W-1:0] rot_z;

	modport source (output valid, rot_x, rot_y, rot_z, input ready);
	modport sink   (input valid, rot_x, rot_y, rot_z, output ready);
endinterface

interface qrv_cfg_if import qrv_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [QUAT_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

### hdl/qrv_cfg.sv
// ----------------------------------------------------------------------------
// qrv_cfg
// Quaternion register file. Takes one write transaction per cycle and
// resets to the identity rotation.
// ----------------------------------------------------------------------------
module qrv_cfg import qrv_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	qrv_cfg_if.sink   cfg,
	output quat_t     quat
);

	quat_t quat_q;

	assign cfg.ready = 1'b1;
	assign quat      = quat_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quat_q.w <= QUAT_W_RST;
			quat_q.x <= '0;
			quat_q.y <= '0;
			quat_q.z <= '0;
		end else if (cfg.valid) begin
			case (cfg_idx_t'(cfg.index))
				REG_QUAT_W: quat_q.w <= cfg.data;
				REG_QUAT_X: quat_q.x <= cfg.data;
				REG_QUAT_Y: quat_q.y <= cfg.data;
				REG_QUAT_Z: quat_q.z <= cfg.data;
				default: ;
			endcase
		end
	end

endmodule

### hdl/qrv_cross.sv
// ----------------------------------------------------------------------------
// qrv_cross
// First two pipeline stages: partial products of qv x v, then the
// differences rounded to the integer vector u.
// ----------------------------------------------------------------------------
module qrv_cross import qrv_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  quat_t quat,
	input  logic  in_valid,
	output logic  in_ready,
	input  vec3_t in_vec,
	output logic  u_valid,
	input  logic  u_ready,
	output ustg_t u_data
);

	logic    vld_s1, vld_s2;
	logic    en_s1, en_s2;
	xprod1_t prod_s1;
	vec3_t   vec_s1;
	ustg_t   data_s2;

	// A stage loads when empty or when its contents move on
	assign en_s2    = !vld_s2 || u_ready;
	assign en_s1    = !vld_s1 || en_s2;
	assign in_ready = en_s1;
	assign u_valid  = vld_s2;
	assign u_data   = data_s2;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= in_valid;
			if (en_s2) vld_s2 <= vld_s1;
		end
	end

	// Stage 1: partial products
	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			prod_s1.yz <= quat.y * in_vec.z;
			prod_s1.zy <= quat.z * in_vec.y;
			prod_s1.zx <= quat.z * in_vec.x;
			prod_s1.xz <= quat.x * in_vec.z;
			prod_s1.xy <= quat.x * in_vec.y;
			prod_s1.yx <= quat.y * in_vec.x;
			vec_s1     <= in_vec;
		end
	end

	// Stage 2: differences, rounded by 2^QF
	always_ff @(posedge clk) begin
		if (en_s2 && vld_s1) begin
			data_s2.u.x <= rnd_u(D1_W'(prod_s1.yz) - D1_W'(prod_s1.zy));
			data_s2.u.y <= rnd_u(D1_W'(prod_s1.zx) - D1_W'(prod_s1.xz));
			data_s2.u.z <= rnd_u(D1_W'(prod_s1.xy) - D1_W'(prod_s1.yx));
			data_s2.v   <= vec_s1;
		end
	end

endmodule

### hdl/qrv_rot.sv
// ----------------------------------------------------------------------------
// qrv_rot
// Last three pipeline stages: products w*u and qv x u, rounding by
// 2^(QF-1), then the final sum with saturation into the output register.
// ----------------------------------------------------------------------------
module qrv_rot import qrv_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  quat_t quat,
	input  logic  u_valid,
	output logic  u_ready,
	input  ustg_t u_data,
	output logic  out_valid,
	input  logic  out_ready,
	output vec3_t out_vec
);

	logic    vld_s3, vld_s4, vld_s5;
	logic    en_s3, en_s4, en_s5;
	wprod_t  wp_s3;
	xprod2_t xp_s3;
	vec3_t   vec_s3, vec_s4, rot_s5;
	logic signed [S_W-1:0]  sx_s4, sy_s4, sz_s4;
	logic signed [DD_W-1:0] dx_s4, dy_s4, dz_s4;
	logic signed [DD_W-1:0] rx, ry, rz;

	// Stage enables
	assign en_s5     = !vld_s5 || out_ready;
	assign en_s4     = !vld_s4 || en_s5;
	assign en_s3     = !vld_s3 || en_s4;
	assign u_ready   = en_s3;
	assign out_valid = vld_s5;
	assign out_vec   = rot_s5;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (en_s3) vld_s3 <= u_valid;
			if (en_s4) vld_s4 <= vld_s3;
			if (en_s5) vld_s5 <= vld_s4;
		end
	end

	// Stage 3: w*u and partial products of qv x u
	always_ff @(posedge clk) begin
		if (en_s3 && u_valid) begin
			wp_s3.x  <= quat.w * u_data.u.x;
			wp_s3.y  <= quat.w * u_data.u.y;
			wp_s3.z  <= quat.w * u_data.u.z;
			xp_s3.yz <= quat.y * u_data.u.z;
			xp_s3.zy <= quat.z * u_data.u.y;
			xp_s3.zx <= quat.z * u_data.u.x;
			xp_s3.xz <= quat.x * u_data.u.z;
			xp_s3.xy <= quat.x * u_data.u.y;
			xp_s3.yx <= quat.y * u_data.u.x;
			vec_s3   <= u_data.v;
		end
	end

	// Rounded 2*w*u terms
	assign rx = rnd_r(D2_W'(wp_s3.x));
	assign ry = rnd_r(D2_W'(wp_s3.y));
	assign rz = rnd_r(D2_W'(wp_s3.z));

	// Stage 4: rounding by 2^(QF-1)
	always_ff @(posedge clk) begin
		if (en_s4 && vld_s3) begin
			sx_s4  <= rx[S_W-1:0];
			sy_s4  <= ry[S_W-1:0];
			sz_s4  <= rz[S_W-1:0];
			dx_s4  <= rnd_r(D2_W'(xp_s3.yz) - D2_W'(xp_s3.zy));
			dy_s4  <= rnd_r(D2_W'(xp_s3.zx) - D2_W'(xp_s3.xz));
			dz_s4  <= rnd_r(D2_W'(xp_s3.xy) - D2_W'(xp_s3.yx));
			vec_s4 <= vec_s3;
		end
	end

	// Stage 5: v + s + d, clamped; this is the output register
	always_ff @(posedge clk) begin
		if (en_s5 && vld_s4) begin
			rot_s5.x <= sat_vec(SUM_W'(vec_s4.x) + SUM_W'(sx_s4) + SUM_W'(dx_s4));
			rot_s5.y <= sat_vec(SUM_W'(vec_s4.y) + SUM_W'(sy_s4) + SUM_W'(dy_s4));
			rot_s5.z <= sat_vec(SUM_W'(vec_s4.z) + SUM_W'(sz_s4) + SUM_W'(dz_s4));
		end
	end

endmodule

### hdl/quat_rotate_vector_core.sv
// ----------------------------------------------------------------------------
// quat_rotate_vector_core
// Rotates a stream of 3-D vectors by the quaternion held in registers.
// Throughput: one vector per cycle while the result side is ready; each of the five stages holds one vector.
// Reset clears all stage valid bits and loads the identity quaternion.
// ----------------------------------------------------------------------------
module quat_rotate_vector_core import qrv_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	qrv_vec_if.sink   vec,
	qrv_rot_if.source rot,
	qrv_cfg_if.sink   cfg
);

	quat_t quat;
	vec3_t in_vec, out_vec;
	logic  u_valid, u_ready;
	ustg_t u_data;

	assign in_vec.x = vec.vec_x;
	assign in_vec.y = vec.vec_y;
	assign in_vec.z = vec.vec_z;

	assign rot.rot_x = out_vec.x;
	assign rot.rot_y = out_vec.y;
	assign rot.rot_z = out_vec.z;

	// Quaternion registers
	qrv_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.quat   (quat)
	);

	// Stages 1-2: u = qv x v
	qrv_cross u_cross (
		.clk      (clk),
		.arst_n   (arst_n),
		.quat     (quat),
		.in_valid (vec.valid),
		.in_ready (vec.ready),
		.in_vec   (in_vec),
		.u_valid  (u_valid),
		.u_ready  (u_ready),
		.u_data   (u_data)
	);

	// Stages 3-5: v + 2wu + 2(qv x u)
	qrv_rot u_rot (
		.clk       (clk),
		.arst_n    (arst_n),
		.quat      (quat),
		.u_valid   (u_valid),
		.u_ready   (u_ready),
		.u_data    (u_data),
		.out_valid (rot.valid),
		.out_ready (rot.ready),
		.out_vec   (out_vec)
	);

	// Pure scalar quaternion gives a zero cross product
	a_identity_u: assert property (@(posedge clk) disable iff (!arst_n)
		(u_valid && quat.x == '0 && quat.y == '0 && quat.z == '0) |-> (u_data.u == '0))
		else $error("nonzero u with zero quaternion vector part");

	// Input stalls only when both front stages are full and blocked
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!vec.ready |-> (u_valid && !u_ready))
		else $error("input stalled while front stages can advance");

	// A blocked internal transaction is held intact
	a_u_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(u_valid && !u_ready) |=> (u_valid && $stable(u_data)))
		else $error("internal transaction lost or changed under stall");

endmodule

### dv/quat_rotate_vector_core_tb.sv
// ----------------------------------------------------------------------------
// quat_rotate_vector_core_tb
// Self-checking bench for the quaternion vector rotation core. A directed
// table covers the reset identity, field extremes, rounding ties and
// saturating non-unit quaternions. Random quaternion phases with random
// vectors follow. Each result is compared with a bit-exact predictor, and
// both handshake sides idle and stall at random.
// ----------------------------------------------------------------------------
module quat_rotate_vector_core_tb import qrv_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RAND_ITEMS   = 1950;
	localparam int DRAIN_CYCLES = 20;    // several times the pipeline latency
	localparam int IDLE_LIMIT   = 1000;  // cycles without any transaction
	localparam int DIR_N        = 24;

	logic clk;
	logic arst_n;

	qrv_vec_if vec_ch ();
	qrv_rot_if rot_ch ();
	qrv_cfg_if cfg_ch ();

	quat_rotate_vector_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.vec    (vec_ch),
		.rot    (rot_ch),
		.cfg    (cfg_ch)
	);

	// Quaternion as the bench believes the core holds it
	quat_t cur_quat;
	// Rotated vectors still owed by the core, oldest first
	vec3_t pending_rot[$];

	int  err_count;
	int  items_sent;
	int  results_checked;
	int  quat_phases;
	int  idle_cycles;
	bit  src_fast;
	bit  sink_fast;

	// Directed table: w, x, y, z, vx, vy, vz, typed, ex, ey, ez
	// Rows with typed = 1 carry their expected result; others use the predictor.
	int dir_tab [DIR_N][11] = '{
		// reset identity: output equals input
		'{32767, 0, 0, 0,      0,      0,      0, 1,      0,      0,      0},
		'{32767, 0, 0, 0,  32767,  32767,  32767, 1,  32767,  32767,  32767},
		'{32767, 0, 0, 0, -32768, -32768, -32768, 1, -32768, -32768, -32768},
		'{32767, 0, 0, 0,      1,     -1, -21846, 1,      1,     -1, -21846},
		'{32767, 0, 0, 0,  21845, -32768,  12345, 1,  21845, -32768,  12345},
		// zero vector part with most negative and zero scalar: still identity
		'{-32768, 0, 0, 0, -32768, 32767,     -1, 1, -32768,  32767,     -1},
		'{0,      0, 0, 0,   1000, -2000,   3000, 1,   1000,  -2000,   3000},
		// quarter turn about z
		'{23170, 0, 0, 23170, 10000,      0,   0, 0, 0, 0, 0},
		'{23170, 0, 0, 23170,     0,  10000,   0, 0, 0, 0, 0},
		'{23170, 0, 0, 23170, 32767, -32768, 100, 0, 0, 0, 0},
		// half turn about x
		'{0, 32767, 0, 0,    100,   200,    300, 0, 0, 0, 0},
		'{0, 32767, 0, 0, -32768, 32767, -32768, 0, 0, 0, 0},
		// non-unit quaternions, saturating outputs
		'{32767, 32767, 32767, 32767,  32767,  32767,  32767, 0, 0, 0, 0},
		'{32767, 32767, 32767, 32767,  32767, -32768,      0, 0, 0, 0, 0},
		'{-32768, -32768, -32768, -32768,  32767, -32768, 32767, 0, 0, 0, 0},
		'{-32768, -32768, -32768, -32768, -32768, -32768, 32767, 0, 0, 0, 0},
		'{32767, -32768, 32767, -32768,  32767,  32767, -32768, 0, 0, 0, 0},
		'{32767, -32768, 32767, -32768,      1,     -1,      1, 0, 0, 0, 0},
		// half-way products: ties round away from zero
		'{0, 16384, 0, 0, 0,  1,  0, 0, 0, 0, 0},
		'{0, 16384, 0, 0, 0, -1,  0, 0, 0, 0, 0},
		'{0, 16384, 0, 0, 0,  3, -3, 0, 0, 0, 0},
		// third of a turn about the diagonal
		'{16384, 16384, 16384, 16384,   1000, 2000,  3000, 0, 0, 0, 0},
		'{16384, 16384, 16384, 16384, -32768,    0, 32767, 0, 0, 0, 0},
		// back to the reset value
		'{32767, 0, 0, 0, -5, 7, -9, 1, -5, 7, -9}
	};

	// Clock and reset
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// ---------------- predictor ----------------

	// x / 2^sh to nearest, ties away from zero
	function automatic longint round_away(longint x, int sh);
		longint half;
		half = longint'(1) << (sh - 1);
		if (x >= 0) begin
			return (x + half) >>> sh;
		end
		return -((-x + half) >>> sh);
	endfunction

	function automatic logic signed [VEC_W-1:0] clamp_vec(longint x);
		longint hi;
		longint lo;
		hi = (longint'(1) << (VEC_W - 1)) - 1;
		lo = -hi - 1;
		if (x > hi) begin
			return hi[VEC_W-1:0];
		end else if (x < lo) begin
			return lo[VEC_W-1:0];
		end
		return x[VEC_W-1:0];
	endfunction

	// v + 2w(qv x v) + 2 qv x (qv x v), with the core's rounding and clamp
	function automatic vec3_t rotated_vec(vec3_t v);
		longint qw, qx, qy, qz;
		longint vx, vy, vz;
		longint ux, uy, uz;
		longint sx, sy, sz;
		longint dx, dy, dz;
		vec3_t  r;
		qw = longint'(cur_quat.w);
		qx = longint'(cur_quat.x);
		qy = longint'(cur_quat.y);
		qz = longint'(cur_quat.z);
		vx = longint'(v.x);
		vy = longint'(v.y);
		vz = longint'(v.z);
		ux = round_away(qy * vz - qz * vy, QF);
		uy = round_away(qz * vx - qx * vz, QF);
		uz = round_away(qx * vy - qy * vx, QF);
		sx = round_away(qw * ux, QF - 1);
		sy = round_away(qw * uy, QF - 1);
		sz = round_away(qw * uz, QF - 1);
		dx = round_away(qy * uz - qz * uy, QF - 1);
		dy = round_away(qz * ux - qx * uz, QF - 1);
		dz = round_away(qx * uy - qy * ux, QF - 1);
		r.x = clamp_vec(vx + sx + dx);
		r.y = clamp_vec(vy + sy + dy);
		r.z = clamp_vec(vz + sz + dz);
		return r;
	endfunction

	// ---------------- random values ----------------

	function automatic logic signed [VEC_W-1:0] rand_comp();
		int pick;
		pick = $urandom_range(0, 9);
		case (pick)
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return '0;
			3, 4: return VEC_W'($urandom_range(0, 200) - 100);
			default: return VEC_W'($urandom);
		endcase
	endfunction

	function automatic vec3_t rand_vec();
		vec3_t v;
		v.x = rand_comp();
		v.y = rand_comp();
		v.z = rand_comp();
		return v;
	endfunction

	function automatic logic signed [QUAT_W-1:0] rand_extreme();
		int pick;
		pick = $urandom_range(0, 2);
		case (pick)
			0: return 16'sh8000;
			1: return 16'sh7fff;
			default: return '0;
		endcase
	endfunction

	function automatic quat_t rand_quat();
		quat_t q;
		int    kind;
		kind = $urandom_range(0, 4);
		case (kind)
			// arbitrary, mostly non-unit
			0: begin
				q.w = QUAT_W'($urandom);
				q.x = QUAT_W'($urandom);
				q.y = QUAT_W'($urandom);
				q.z = QUAT_W'($urandom);
			end
			// extremes only
			1: begin
				q.w = rand_extreme();
				q.x = rand_extreme();
				q.y = rand_extreme();
				q.z = rand_extreme();
			end
			// norm at most one: little saturation
			2: begin
				q.w = QUAT_W'($urandom_range(0, 32766) - 16383);
				q.x = QUAT_W'($urandom_range(0, 32766) - 16383);
				q.y = QUAT_W'($urandom_range(0, 32766) - 16383);
				q.z = QUAT_W'($urandom_range(0, 32766) - 16383);
			end
			// single-axis rotation
			3: begin
				q = '0;
				q.w = QUAT_W'($urandom);
				case ($urandom_range(0, 2))
					0: q.x = QUAT_W'($urandom);
					1: q.y = QUAT_W'($urandom);
					default: q.z = QUAT_W'($urandom);
				endcase
			end
			default: begin
				q = '0;
				q.w = QUAT_W_RST;
			end
		endcase
		return q;
	endfunction

	// ---------------- stimulus ----------------

	// One input transaction; the expectation is queued at acceptance
	task automatic send_vec(vec3_t v, bit typed, vec3_t typed_rot);
		int gap;
		gap = src_fast ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			vec_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		vec_ch.valid <= 1'b1;
		vec_ch.vec_x <= v.x;
		vec_ch.vec_y <= v.y;
		vec_ch.vec_z <= v.z;
		do @(posedge clk); while (vec_ch.ready !== 1'b1);
		pending_rot.push_back(typed ? typed_rot : rotated_vec(v));
		items_sent++;
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [QUAT_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		case (idx)
			REG_QUAT_W: cur_quat.w = value;
			REG_QUAT_X: cur_quat.x = value;
			REG_QUAT_Y: cur_quat.y = value;
			REG_QUAT_Z: cur_quat.z = value;
			default: ;
		endcase
	endtask

	// Let the pipeline empty, then load a new quaternion
	task automatic load_quat(quat_t q);
		vec_ch.valid <= 1'b0;
		while (pending_rot.size() != 0) @(posedge clk);
		write_reg(REG_QUAT_W, q.w);
		write_reg(REG_QUAT_X, q.x);
		write_reg(REG_QUAT_Y, q.y);
		write_reg(REG_QUAT_Z, q.z);
		cfg_ch.valid <= 1'b0;
		quat_phases++;
	endtask

	// Main sequence
	initial begin
		quat_t q;
		vec3_t v;
		vec3_t e;
		int    n;
		arst_n       <= 1'b0;
		vec_ch.valid <= 1'b0;
		vec_ch.vec_x <= '0;
		vec_ch.vec_y <= '0;
		vec_ch.vec_z <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= REG_QUAT_W;
		cfg_ch.data  <= '0;
		cur_quat     = '0;
		cur_quat.w   = QUAT_W_RST;
		err_count    = 0;
		items_sent   = 0;
		quat_phases  = 0;
		src_fast     = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table
		for (int i = 0; i < DIR_N; i++) begin
			q.w = dir_tab[i][0][QUAT_W-1:0];
			q.x = dir_tab[i][1][QUAT_W-1:0];
			q.y = dir_tab[i][2][QUAT_W-1:0];
			q.z = dir_tab[i][3][QUAT_W-1:0];
			v.x = dir_tab[i][4][VEC_W-1:0];
			v.y = dir_tab[i][5][VEC_W-1:0];
			v.z = dir_tab[i][6][VEC_W-1:0];
			e.x = dir_tab[i][8][VEC_W-1:0];
			e.y = dir_tab[i][9][VEC_W-1:0];
			e.z = dir_tab[i][10][VEC_W-1:0];
			if (q != cur_quat) begin
				load_quat(q);
			end
			send_vec(v, dir_tab[i][7] != 0, e);
		end

		// Random phases: new quaternion, then a run of random vectors
		while (items_sent < DIR_N + RAND_ITEMS) begin
			load_quat(rand_quat());
			src_fast = ($urandom_range(0, 3) == 0);
			n = $urandom_range(20, 120);
			for (int k = 0; k < n && items_sent < DIR_N + RAND_ITEMS; k++) begin
				send_vec(rand_vec(), 1'b0, '0);
			end
		end

		// Drain and let any stray result show up
		vec_ch.valid <= 1'b0;
		while (pending_rot.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d vectors under %0d quaternion settings, checked %0d results.",
			items_sent, quat_phases, results_checked);
		$display("Mismatches or unexpected results: %0d, left pending: %0d.",
			err_count, pending_rot.size());
		if (err_count == 0 && pending_rot.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// ---------------- result side ----------------

	// Ready is dropped for a random stall before each result, with stall-free stretches
	initial begin
		int stall;
		rot_ch.ready <= 1'b0;
		sink_fast = 1'b0;
		@(posedge clk);
		while (arst_n !== 1'b1) @(posedge clk);
		forever begin
			if ($urandom_range(0, 31) == 0) begin
				sink_fast = ~sink_fast;
			end
			stall = sink_fast ? 0 : $urandom_range(0, 7);
			if (stall > 0) begin
				rot_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rot_ch.ready <= 1'b1;
			do @(posedge clk); while (rot_ch.valid !== 1'b1);
		end
	end

	function automatic void check_comp(string name, logic signed [VEC_W-1:0] exp_val,
			logic signed [VEC_W-1:0] act_val);
		if (exp_val !== act_val) begin
			$display("%0t: rot_%s mismatch, expected %0d, got %0d",
				$time, name, exp_val, act_val);
			err_count++;
		end
	endfunction

	// Compare each result transaction with the oldest expectation
	always @(posedge clk) begin
		vec3_t exp_rot;
		if (rot_ch.valid === 1'b1 && rot_ch.ready === 1'b1) begin
			if (pending_rot.size() == 0) begin
				$display("%0t: unexpected result (%0d, %0d, %0d)",
					$time, rot_ch.rot_x, rot_ch.rot_y, rot_ch.rot_z);
				err_count++;
			end else begin
				exp_rot = pending_rot.pop_front();
				check_comp("x", exp_rot.x, rot_ch.rot_x);
				check_comp("y", exp_rot.y, rot_ch.rot_y);
				check_comp("z", exp_rot.z, rot_ch.rot_z);
				results_checked++;
			end
		end
	end

	// Watchdog: no transaction on any channel for too long
	always @(posedge clk) begin
		if ((vec_ch.valid === 1'b1 && vec_ch.ready === 1'b1) ||
				(rot_ch.valid === 1'b1 && rot_ch.ready === 1'b1) ||
				(cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: timeout, %0d results still pending", $time, pending_rot.size());
			$display("Verification failed");
			$finish;
		end
	end

	initial idle_cycles = 0;
	initial results_checked = 0;

endmodule
